// ===== src/idp_pkg.sv =====
// Shared types and constants for the integer dot product block.
// Used by idp_lane, idp_merge and integer_dot_product; depends on nothing.
package idp_pkg;

   localparam int DataWidth    = 64;
   localparam int DefaultLanes = 8;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   typedef enum logic [1:0] {
      EW_INT8  = 2'd0,
      EW_INT16 = 2'd1,
      EW_INT32 = 2'd2,
      EW_INT64 = 2'd3
   } elem_width_type;

   typedef enum logic {
      REG_ELEMENT_WIDTH = 1'b0
   } csr_reg_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

   function automatic logic [3:0] elems_per_word(elem_width_type ew);
      logic [3:0] n;
      unique case (ew)
         EW_INT8:  n = 4'd8;
         EW_INT16: n = 4'd4;
         EW_INT32: n = 4'd2;
         EW_INT64: n = 4'd1;
         default:  n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== src/idp_lane.sv =====
// One multiply lane: extracts its element pair, multiplies, and forms a 64-bit product.
// Two register stages. The lane with WIDE set also forms the 64-bit cross terms.
// Depends on idp_pkg.
module idp_lane #(
   parameter int LANE_IDX = 0,
   parameter bit WIDE     = 1'b0
) (
   input  logic                            clock,
   input  logic                            advance,
   input  logic                            lane_en,
   input  idp_pkg::elem_width_type         elem_width,
   input  logic [idp_pkg::DataWidth-1:0]   a_word,
   input  logic [idp_pkg::DataWidth-1:0]   b_word,
   output logic [idp_pkg::DataWidth-1:0]   prod
);

   localparam int I8  = LANE_IDX % 8;
   localparam int I16 = LANE_IDX % 4;
   localparam int I32 = LANE_IDX % 2;

   logic signed [32:0]               op_a;
   logic signed [32:0]               op_b;
   logic signed [65:0]               full_p;
   logic [idp_pkg::DataWidth-1:0]    main_ff;
   logic [idp_pkg::DataWidth-1:0]    prod_ff;

   always_comb begin
      op_a = '0;
      op_b = '0;
      if (lane_en) begin
         unique case (elem_width)
            idp_pkg::EW_INT8: begin
               op_a = 33'($signed(a_word[8*I8 +: 8]));
               op_b = 33'($signed(b_word[8*I8 +: 8]));
            end
            idp_pkg::EW_INT16: begin
               op_a = 33'($signed(a_word[16*I16 +: 16]));
               op_b = 33'($signed(b_word[16*I16 +: 16]));
            end
            idp_pkg::EW_INT32: begin
               op_a = 33'($signed(a_word[32*I32 +: 32]));
               op_b = 33'($signed(b_word[32*I32 +: 32]));
            end
            idp_pkg::EW_INT64: begin
               // low halves, unsigned; cross terms complete the product
               op_a = {1'b0, a_word[31:0]};
               op_b = {1'b0, b_word[31:0]};
            end
            default: begin
               op_a = '0;
               op_b = '0;
            end
         endcase
      end
   end

   assign full_p = op_a * op_b;

   always_ff @(posedge clock) begin
      if (advance) begin
         main_ff <= full_p[63:0];
      end
   end

   if (WIDE) begin : g_wide
      logic [31:0] xa_lo;
      logic [31:0] xb_hi;
      logic [31:0] xa_hi;
      logic [31:0] xb_lo;
      logic [63:0] c1_full;
      logic [63:0] c2_full;
      logic [31:0] c1_ff;
      logic [31:0] c2_ff;
      logic [31:0] cross_sum;

      always_comb begin
         xa_lo = '0;
         xb_hi = '0;
         xa_hi = '0;
         xb_lo = '0;
         if (lane_en && (elem_width == idp_pkg::EW_INT64)) begin
            xa_lo = a_word[31:0];
            xb_hi = b_word[63:32];
            xa_hi = a_word[63:32];
            xb_lo = b_word[31:0];
         end
      end

      assign c1_full   = xa_lo * xb_hi;
      assign c2_full   = xa_hi * xb_lo;
      assign cross_sum = c1_ff + c2_ff;

      always_ff @(posedge clock) begin
         if (advance) begin
            c1_ff   <= c1_full[31:0];
            c2_ff   <= c2_full[31:0];
            prod_ff <= main_ff + {cross_sum, 32'd0};
         end
      end
   end else begin : g_narrow
      always_ff @(posedge clock) begin
         if (advance) begin
            prod_ff <= main_ff;
         end
      end
   end

   assign prod = prod_ff;

endmodule

// ===== src/idp_merge.sv =====
// Registered adder tree that sums the lane products, one tree level per stage.
// Carries the item's valid and last flags alongside. Depends on idp_pkg.
module idp_merge #(
   parameter int LANES = idp_pkg::DefaultLanes
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  idp_pkg::stage_ctl_type                   in_ctl,
   input  logic [LANES-1:0][idp_pkg::DataWidth-1:0] lane_prod,
   output idp_pkg::stage_ctl_type                   out_ctl,
   output logic [idp_pkg::DataWidth-1:0]            out_sum
);

   localparam int Levels = $clog2(LANES);
   localparam int Pad    = 1 << Levels;

   if (Levels == 0) begin : g_single
      assign out_sum = lane_prod[0];
      assign out_ctl = in_ctl;
   end else begin : g_tree
      logic [idp_pkg::DataWidth-1:0] leaf [Pad];
      logic [idp_pkg::DataWidth-1:0] tree_ff [1:Pad-1];
      idp_pkg::stage_ctl_type        ctl_ff [Levels];

      for (genvar j = 0; j < Pad; j++) begin : g_leaf
         if (j < LANES) begin : g_used
            assign leaf[j] = lane_prod[j];
         end else begin : g_pad
            assign leaf[j] = '0;
         end
      end

      // heap order: node k sums nodes 2k and 2k+1, leaves sit at Pad..2*Pad-1
      for (genvar k = 1; k < Pad; k++) begin : g_node
         if (2 * k >= Pad) begin : g_bottom
            always_ff @(posedge clock) begin
               if (advance) begin
                  tree_ff[k] <= leaf[2*k-Pad] + leaf[2*k+1-Pad];
               end
            end
         end else begin : g_inner
            always_ff @(posedge clock) begin
               if (advance) begin
                  tree_ff[k] <= tree_ff[2*k] + tree_ff[2*k+1];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            for (int s = 0; s < Levels; s++) begin
               ctl_ff[s] <= '0;
            end
         end else if (advance) begin
            ctl_ff[0] <= in_ctl;
            for (int s = 1; s < Levels; s++) begin
               ctl_ff[s] <= ctl_ff[s-1];
            end
         end
      end

      assign out_sum = tree_ff[1];
      assign out_ctl = ctl_ff[Levels-1];
   end

endmodule

// ===== src/integer_dot_product.sv =====
// Top level of the streaming integer dot product: lanes, merge tree, accumulator, CSR port.
// Depends on idp_pkg, idp_lane and idp_merge.
//
// Takes one item (a 64-bit word of each vector) per clock while intake runs. A result is
// posted once its last item has passed each register: the lane multipliers register at
// the edge that takes it, then one stage folds the 64-bit cross terms into the lane product,
// one stage per level of the adder tree, and one for the accumulator add. Intake pauses
// only while a last item sits at the accumulator and the previous sum is still unread on
// the result port. element_width may be written only while the block is idle.
module integer_dot_product #(
   parameter int LANES = idp_pkg::DefaultLanes
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [idp_pkg::DataWidth-1:0]         req_a_word,
   input  logic [idp_pkg::DataWidth-1:0]         req_b_word,
   input  logic [3:0]                            req_valid_count,
   input  logic                                  req_last,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [idp_pkg::DataWidth-1:0]  rsp_sum,
   // configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [idp_pkg::CsrAddrWidth-1:0]      csr_paddr,
   input  logic [idp_pkg::CsrDataWidth-1:0]      csr_pwdata,
   output logic [idp_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   idp_pkg::elem_width_type                  ew_ff;
   idp_pkg::elem_width_type                  ew_in;
   logic                                     csr_write;
   idp_pkg::csr_reg_type                     csr_reg;

   logic                                     advance;
   logic [3:0]                               per_word;
   logic [4:0]                               cnt;
   logic [LANES-1:0]                         lane_en;
   logic [LANES-1:0][idp_pkg::DataWidth-1:0] lane_prod;

   idp_pkg::stage_ctl_type                   s1_ff;
   idp_pkg::stage_ctl_type                   s2_ff;
   idp_pkg::stage_ctl_type                   m_ctl;
   logic [idp_pkg::DataWidth-1:0]            m_sum;
   logic                                     emit;

   logic [idp_pkg::DataWidth-1:0]            acc_ff;
   logic [idp_pkg::DataWidth-1:0]            acc_in;
   logic                                     rsp_valid_ff;
   logic                                     rsp_valid_in;
   logic [idp_pkg::DataWidth-1:0]            rsp_sum_ff;
   logic [idp_pkg::DataWidth-1:0]            rsp_sum_in;

   // ---------------- configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = idp_pkg::csr_reg_type'(csr_paddr[2]);

   always_comb begin
      ew_in = ew_ff;
      if (csr_write) begin
         unique case (csr_reg)
            idp_pkg::REG_ELEMENT_WIDTH: ew_in = idp_pkg::elem_width_type'(csr_pwdata[1:0]);
            default: ew_in = ew_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         idp_pkg::REG_ELEMENT_WIDTH: csr_prdata = {30'd0, ew_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ew_ff <= idp_pkg::EW_INT8;
      end else begin
         ew_ff <= ew_in;
      end
   end

   // ---------------- flow control: stall only a last item facing an unread result
   assign advance   = !(m_ctl.valid && m_ctl.last && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;

   // ---------------- lane enables: count clipped to word capacity and lane count
   assign per_word = idp_pkg::elems_per_word(ew_ff);

   always_comb begin
      cnt = {1'b0, req_valid_count};
      if (cnt > {1'b0, per_word}) begin
         cnt = {1'b0, per_word};
      end
      if (cnt > 5'(LANES)) begin
         cnt = 5'(LANES);
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      assign lane_en[i] = (5'(i) < cnt);

      idp_lane #(
         .LANE_IDX (i),
         .WIDE     (i == 0)
      ) u_lane (
         .clock      (clock),
         .advance    (advance),
         .lane_en    (lane_en[i]),
         .elem_width (ew_ff),
         .a_word     (req_a_word),
         .b_word     (req_b_word),
         .prod       (lane_prod[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else if (advance) begin
         s1_ff <= '{valid: req_valid, last: req_last};
         s2_ff <= s1_ff;
      end
   end

   idp_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (s2_ff),
      .lane_prod (lane_prod),
      .out_ctl   (m_ctl),
      .out_sum   (m_sum)
   );

   // ---------------- accumulator and result register
   assign emit = advance && m_ctl.valid && m_ctl.last;

   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      if (advance && m_ctl.valid) begin
         if (m_ctl.last) begin
            rsp_sum_in   = acc_ff + m_sum;
            rsp_valid_in = 1'b1;
            acc_in       = '0;
         end else begin
            acc_in = acc_ff + m_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;

   // ---------------- assertions
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("intake stalled without a blocked result");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_valid_ff && (acc_ff == '0)))
      else $error("last item did not post a result and clear the accumulator");

   a_wide_single_lane: assert property (@(posedge clock) disable iff (reset)
      (ew_ff == idp_pkg::EW_INT64) |-> $onehot0(lane_en))
      else $error("more than one lane active for 64-bit elements");

   a_lanes_packed: assert property (@(posedge clock) disable iff (reset)
      ((lane_en & (lane_en + 1'b1)) == '0))
      else $error("active lanes are not the low lanes");

endmodule
